[rtl/core/srrw_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
`default_nettype none

package srrw_pkg;

    // Sizes of the sequence space, receive buffer and fields
    localparam int SEQ_SPACE  = 16;
    localparam int RECV_SLOTS = 5;
    localparam int SEQ_W      = 4;
    localparam int CNT_W      = 3;
    localparam int LEN_W      = 11;
    localparam int STEP_W     = $clog2(SEQ_SPACE + 1);

    localparam logic [SEQ_W-1:0] WIN_RESET   = SEQ_W'(5);
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(1024);

    // Event codes
    localparam logic [1:0] FUNC_DATA    = 2'd0;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [1:0] FUNC_CONSUME = 2'd2;

    // Result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_DELIV = 1'b1;

    typedef struct packed {
        logic [1:0]       func;
        logic [SEQ_W-1:0] seq_num;
        logic [LEN_W-1:0] payload_len;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [SEQ_W-1:0] ack_window;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_seq_valid;
        logic [SEQ_W-1:0] slot_index;
        logic [CNT_W-1:0] buffer_index;
        logic [LEN_W-1:0] deliver_len;
        logic             last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN_PRE,
        S_EVENT,
        S_ADVANCE,
        S_DRAIN_POST,
        S_ACK,
        S_FULL_CHK,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        EMIT_DELIV,
        EMIT_ACK,
        EMIT_ACK_TMO
    } t_emit;

    // Commands from controller to datapath
    typedef struct packed {
        logic  capture;
        logic  drain_step;
        logic  clear_full;
        logic  set_full;
        logic  store;
        logic  adv_step;
        logic  consume;
        logic  emit;
        t_emit emit_sel;
        logic  flush;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       base_filled;
        logic       cnt_room;
        logic       exp_filled;
        logic       steps_left;
        logic       reject;
        logic       in_order;
        logic       full;
        logic       rem_zero;
        logic       emit_ok;
        logic       pend_valid;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/srrw_dp.sv]
// Datapath: window slots, pointers, counters and the two-stage result queue.
`default_nettype none

module srrw_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire  [srrw_pkg::SEQ_W-1:0]   i_cfg_data,
    input  wire  srrw_pkg::t_in          i_data,
    input  wire  srrw_pkg::t_cmd         i_cmd,
    output srrw_pkg::t_sts               o_sts,
    input  wire                          i_ready,
    output logic                         o_valid,
    output srrw_pkg::t_out               o_data
);
    import srrw_pkg::*;

    logic [SEQ_SPACE-1:0] r_filled;
    logic [LEN_W-1:0]     r_slot_len [SEQ_SPACE];
    logic [SEQ_W-1:0]     r_win;
    logic [SEQ_W-1:0]     r_base;
    logic [SEQ_W-1:0]     r_exp;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_full;
    logic [STEP_W-1:0]    r_steps;
    logic [1:0]           r_func;
    logic [SEQ_W-1:0]     r_seq;
    logic [LEN_W-1:0]     r_len;
    t_out                 r_pend;
    logic                 r_pend_v;
    t_out                 r_out;
    logic                 r_out_v;

    logic [SEQ_W-1:0] rem;
    logic [SEQ_W-1:0] offset;
    logic             tmo_valid;
    logic             out_free;
    t_out             n_res;
    t_out             n_flush;

    // Window arithmetic wraps in the sequence space
    assign rem       = SEQ_W'(r_win + r_base - r_exp);
    assign offset    = SEQ_W'(r_seq - r_base);
    assign tmo_valid = (r_exp != r_base) || (r_base != '0);
    assign out_free  = !r_out_v || i_ready;

    // Status toward the controller
    always_comb begin
        o_sts.func        = r_func;
        o_sts.base_filled = r_filled[r_base];
        o_sts.cnt_room    = r_cnt < CNT_W'(RECV_SLOTS);
        o_sts.exp_filled  = r_filled[r_exp];
        o_sts.steps_left  = r_steps < STEP_W'(SEQ_SPACE);
        o_sts.reject      = (offset >= r_win) || r_filled[r_seq];
        o_sts.in_order    = r_seq == r_exp;
        o_sts.full        = r_full;
        o_sts.rem_zero    = rem == '0;
        o_sts.emit_ok     = !r_pend_v || out_free;
        o_sts.pend_valid  = r_pend_v;
        o_sts.out_free    = out_free;
    end

    // Build the result selected by the controller
    always_comb begin
        n_res = '0;
        unique case (i_cmd.emit_sel)
            EMIT_DELIV: begin
                n_res.kind         = KIND_DELIV;
                n_res.slot_index   = r_base;
                n_res.buffer_index = r_cnt;
                n_res.deliver_len  = r_slot_len[r_base];
            end
            EMIT_ACK: begin
                n_res.kind          = KIND_ACK;
                n_res.ack_window    = rem;
                n_res.ack_seq       = SEQ_W'(r_exp - 1'b1);
                n_res.ack_seq_valid = 1'b1;
            end
            EMIT_ACK_TMO: begin
                n_res.kind          = KIND_ACK;
                n_res.ack_window    = rem;
                n_res.ack_seq       = tmo_valid ? SEQ_W'(r_exp - 1'b1) : '0;
                n_res.ack_seq_valid = tmo_valid;
            end
            default: n_res = '0;
        endcase
    end

    // Final result of an event carries the last mark
    always_comb begin
        n_flush      = r_pend;
        n_flush.last = 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_win    <= WIN_RESET;
            r_base   <= '0;
            r_exp    <= '0;
            r_cnt    <= '0;
            r_full   <= 1'b0;
            r_steps  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_steps <= '0;
            end
            // Deliver base slot into the receive buffer
            if (i_cmd.drain_step) begin
                r_filled[r_base] <= 1'b0;
                r_base           <= SEQ_W'(r_base + 1'b1);
                r_cnt            <= CNT_W'(r_cnt + 1'b1);
            end
            if (i_cmd.clear_full) begin
                r_full <= 1'b0;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.store) begin
                r_filled[r_seq] <= 1'b1;
            end
            // Walk expected number over filled slots
            if (i_cmd.adv_step) begin
                r_exp   <= SEQ_W'(r_exp + 1'b1);
                r_steps <= STEP_W'(r_steps + 1'b1);
            end
            if (i_cmd.consume && (r_cnt != '0)) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
            // Result queue: pending stage feeds the output stage
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end else if (r_out_v && i_ready) begin
                    r_out_v <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_data.func;
            r_seq  <= i_data.seq_num;
            r_len  <= (i_data.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : i_data.payload_len;
        end
        if (i_cmd.store) begin
            r_slot_len[r_seq] <= r_len;
        end
        if (i_cmd.emit) begin
            r_pend <= n_res;
            if (r_pend_v) begin
                r_out <= r_pend;
            end
        end else if (i_cmd.flush) begin
            r_out <= n_flush;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // Buffer count never passes the buffer depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RECV_SLOTS))
        else $error("receive buffer count overflow");

    // A new result never overwrites a waiting one
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_pend_v || !r_out_v || i_ready))
        else $error("result emitted without queue room");

    // Flush needs a pending result and a free output stage
    a_flush_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pend_v && (!r_out_v || i_ready)))
        else $error("flush without pending result or output room");

    // A drain step clears the base slot and moves the base
    a_drain_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain_step |=> (r_base == SEQ_W'($past(r_base) + 1'b1)))
        else $error("drain step did not advance base");

endmodule

`default_nettype wire

[rtl/core/srrw_ctrl.sv]
// Controller: event sequencer that steps the drain, store, advance and ACK phases.
`default_nettype none

module srrw_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  srrw_pkg::t_sts  i_sts,
    output srrw_pkg::t_cmd        o_cmd
);
    import srrw_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DRAIN_PRE;
                end
            end
            S_DRAIN_PRE, S_DRAIN_POST: begin
                if (i_sts.base_filled && i_sts.cnt_room) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.drain_step = 1'b1;
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_sel   = EMIT_DELIV;
                    end
                end else begin
                    n_state = (r_state == S_DRAIN_PRE) ? S_EVENT : S_ACK;
                end
            end
            S_EVENT: begin
                unique case (i_sts.func)
                    FUNC_DATA: begin
                        if (i_sts.emit_ok) begin
                            o_cmd.clear_full = 1'b1;
                            if (i_sts.reject) begin
                                // Drop out-of-window or duplicate packet
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_sel = EMIT_ACK;
                                n_state        = S_FULL_CHK;
                            end else begin
                                o_cmd.store = 1'b1;
                                if (i_sts.in_order) begin
                                    n_state = S_ADVANCE;
                                end else begin
                                    o_cmd.emit     = 1'b1;
                                    o_cmd.emit_sel = EMIT_ACK;
                                    n_state        = S_FULL_CHK;
                                end
                            end
                        end
                    end
                    FUNC_TIMEOUT: begin
                        if (i_sts.full && !i_sts.rem_zero) begin
                            if (i_sts.emit_ok) begin
                                o_cmd.emit     = 1'b1;
                                o_cmd.emit_sel = EMIT_ACK_TMO;
                                n_state        = S_FULL_CHK;
                            end
                        end else begin
                            n_state = S_FULL_CHK;
                        end
                    end
                    FUNC_CONSUME: begin
                        o_cmd.consume = 1'b1;
                        n_state       = S_FULL_CHK;
                    end
                    default: begin
                        n_state = S_FULL_CHK;
                    end
                endcase
            end
            S_ADVANCE: begin
                if (i_sts.exp_filled && i_sts.steps_left) begin
                    o_cmd.adv_step = 1'b1;
                end else begin
                    n_state = S_DRAIN_POST;
                end
            end
            S_ACK: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_ACK;
                    n_state        = S_FULL_CHK;
                end
            end
            S_FULL_CHK: begin
                if (!i_sts.full && i_sts.rem_zero) begin
                    if (i_sts.emit_ok) begin
                        o_cmd.set_full = 1'b1;
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_ACK;
                        n_state        = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // Release the held result with the last mark
                if (i_sts.pend_valid) begin
                    if (i_sts.out_free) begin
                        o_cmd.flush = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/selective_repeat_receive_window.sv]
// Top level: selective-repeat receive window, controller plus datapath.
// Sequence: a pre-drain, the event, then for an in-order packet an advance walk, a
//   post-drain and an ACK, then a full check and a finish; an output stall holds any
//   step that emits a result.
// Events: one at a time; the next request is taken once the event's last result
//   sits in the output register.
// Reset: synchronous, active low; clears slot flags, pointers, counters, full mark and
//   queue valids, and sets the window size to 5. Stored lengths are not cleared.
`default_nettype none

module selective_repeat_receive_window (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  [srrw_pkg::SEQ_W-1:0]  i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire  srrw_pkg::t_in         i_data,
    output logic                        o_valid,
    input  wire                         i_ready,
    output srrw_pkg::t_out              o_data
);
    import srrw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Accept register writes at any time
    assign o_cfg_ready = 1'b1;

    srrw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    srrw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire
